[hdl/pdu_pkg.sv]
// Package for the pressureless dust upwind flux block: widths, codes and
// stage payload types shared by the interfaces and all pipeline modules.
// No dependencies.
`timescale 1ns / 1ps
package pdu_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int FIELD_W   = 32;
   localparam int FRAC_BITS = 16;
   localparam int FLUX_W    = 48;
   localparam int SUM_W     = FLUX_W + 1;
   localparam int MOM_W     = 64;
   localparam int OP_W      = FIELD_W + 1;
   localparam int SPLIT_W   = 24;
   localparam int ROE_W     = 3 * FIELD_W;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_SOLVER_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_DIR  = 2'd1;

   localparam logic [1:0] DIR_X = 2'd0;
   localparam logic [1:0] DIR_Y = 2'd1;
   localparam logic [1:0] DIR_Z = 2'd2;

   typedef enum logic {
      MODE_PENETRATE = 1'b0,
      MODE_ROE       = 1'b1
   } solver_mode_type;

   typedef enum logic [1:0] {
      SIGN_NEG  = 2'd0,
      SIGN_ZERO = 2'd1,
      SIGN_POS  = 2'd2
   } roe_sign_type;

   typedef logic [FIELD_W-1:0] field_type;

   typedef struct packed {
      field_type       rho_l;
      field_type [2:0] v_l;
      field_type       rho_r;
      field_type [2:0] v_r;
   } item_type;

   typedef struct packed {
      logic lpos;
      logic lneg;
      logic lzero;
      logic rpos;
      logic rneg;
      logic rzero;
      logic dlz;
      logic drz;
   } side_flags_type;

   typedef struct packed {
      logic signed [FLUX_W-1:0] fl;
      logic signed [FLUX_W-1:0] fr;
      logic signed [FLUX_W-1:0] fsat;
      logic signed [FLUX_W-1:0] fhalf;
      field_type [2:0]          vl;
      field_type [2:0]          vr;
      side_flags_type           flags;
      logic [ROE_W-1:0]         roe_l;
      logic [ROE_W-1:0]         roe_r;
   } front_type;

   typedef struct packed {
      logic signed [FLUX_W-1:0] mass;
      logic signed [FLUX_W-1:0] b_l;
      logic signed [FLUX_W-1:0] b_r;
      logic [2:0][OP_W-1:0]     a_l;
      logic [2:0][OP_W-1:0]     a_r;
      logic                     en_l;
      logic                     en_r;
      logic                     half;
   } sel_type;

   typedef struct packed {
      logic [FLUX_W-1:0]         mass;
      logic [2:0][MOM_W-1:0]     mom;
   } result_type;

endpackage

[hdl/pdu_if.sv]
// Channel interfaces for the dust flux block: face item, flux result and
// register write. Depends on pdu_pkg.
`timescale 1ns / 1ps
interface pdu_req_if;
   logic                valid;
   logic                ready;
   pdu_pkg::field_type  rho_left;
   pdu_pkg::field_type  vx_left;
   pdu_pkg::field_type  vy_left;
   pdu_pkg::field_type  vz_left;
   pdu_pkg::field_type  rho_right;
   pdu_pkg::field_type  vx_right;
   pdu_pkg::field_type  vy_right;
   pdu_pkg::field_type  vz_right;
   modport source (output valid, rho_left, vx_left, vy_left, vz_left,
                   rho_right, vx_right, vy_right, vz_right, input ready);
   modport sink (input valid, rho_left, vx_left, vy_left, vz_left,
                 rho_right, vx_right, vy_right, vz_right, output ready);
endinterface

interface pdu_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [pdu_pkg::FLUX_W-1:0]   mass_flux;
   logic signed [pdu_pkg::MOM_W-1:0]    mom_flux_x;
   logic signed [pdu_pkg::MOM_W-1:0]    mom_flux_y;
   logic signed [pdu_pkg::MOM_W-1:0]    mom_flux_z;
   modport source (output valid, mass_flux, mom_flux_x, mom_flux_y, mom_flux_z,
                   input ready);
   modport sink (input valid, mass_flux, mom_flux_x, mom_flux_y, mom_flux_z,
                 output ready);
endinterface

interface pdu_csr_if;
   logic                              valid;
   logic                              ready;
   logic [pdu_pkg::CSR_IDX_W-1:0]     index;
   logic [pdu_pkg::CSR_DATA_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[hdl/pdu_front.sv]
// Front stages 1-3: normal side fluxes, truncation, mass sums and the
// density-weighted squared velocities for the Roe sign. Depends on pdu_pkg.
`timescale 1ns / 1ps
module pdu_front #(
   parameter int VALUE_WIDTH = pdu_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          normal_dir,
   input  logic                in_valid,
   output logic                in_ready,
   input  pdu_pkg::item_type   in_item,
   output logic                out_valid,
   input  logic                out_ready,
   output pdu_pkg::front_type  out_data
);
   import pdu_pkg::*;

   localparam int EXT = FIELD_W - VALUE_WIDTH;
   localparam int PROD_W = 2 * FIELD_W;

   field_type                 dl_c, dr_c;
   field_type [2:0]           vl_c, vr_c;
   logic signed [FIELD_W-1:0] vnl_c, vnr_c;
   logic [FIELD_W-1:0]        magl_c, magr_c;
   logic signed [PROD_W:0]    pl_c, pr_c;
   logic [PROD_W-1:0]         sql_c, sqr_c;
   side_flags_type            flags_c;

   logic                      v1_ff, v2_ff, v3_ff;
   logic                      rdy1, rdy2, rdy3;

   logic signed [PROD_W-1:0]  s1_pl_ff, s1_pr_ff;
   logic [PROD_W-1:0]         s1_sql_ff, s1_sqr_ff;
   field_type                 s1_dl_ff, s1_dr_ff;
   field_type [2:0]           s1_vl_ff, s1_vr_ff;
   side_flags_type            s1_flags_ff;

   logic signed [PROD_W-1:0]  tl_c, tr_c, shl_c, shr_c;
   logic [PROD_W-1:0]         ll_c, lh_c, rl_c, rh_c;

   logic signed [FLUX_W-1:0]  s2_fl_ff, s2_fr_ff;
   logic [PROD_W-1:0]         s2_ll_ff, s2_lh_ff, s2_rl_ff, s2_rh_ff;
   field_type [2:0]           s2_vl_ff, s2_vr_ff;
   side_flags_type            s2_flags_ff;

   logic signed [SUM_W-1:0]   fsum_c, fbias_c, fhalf_c;
   front_type                 s3_in;
   front_type                 s3_ff;

   assign rdy3 = !v3_ff || out_ready;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_comb begin
      dl_c = (in_item.rho_l << EXT) >> EXT;
      dr_c = (in_item.rho_r << EXT) >> EXT;
      for (int c = 0; c < 3; c++) begin
         vl_c[c] = field_type'($signed(in_item.v_l[c] << EXT) >>> EXT);
         vr_c[c] = field_type'($signed(in_item.v_r[c] << EXT) >>> EXT);
      end
      unique case (normal_dir)
         DIR_Y: begin
            vnl_c = $signed(vl_c[1]);
            vnr_c = $signed(vr_c[1]);
         end
         DIR_Z: begin
            vnl_c = $signed(vl_c[2]);
            vnr_c = $signed(vr_c[2]);
         end
         default: begin
            vnl_c = $signed(vl_c[0]);
            vnr_c = $signed(vr_c[0]);
         end
      endcase
      magl_c = vnl_c[FIELD_W-1] ? FIELD_W'(-vnl_c) : FIELD_W'(vnl_c);
      magr_c = vnr_c[FIELD_W-1] ? FIELD_W'(-vnr_c) : FIELD_W'(vnr_c);
      pl_c = $signed({1'b0, dl_c}) * vnl_c;
      pr_c = $signed({1'b0, dr_c}) * vnr_c;
      sql_c = magl_c * magl_c;
      sqr_c = magr_c * magr_c;
      flags_c.lzero = (vnl_c == '0);
      flags_c.lneg  = vnl_c[FIELD_W-1];
      flags_c.lpos  = !vnl_c[FIELD_W-1] && (vnl_c != '0);
      flags_c.rzero = (vnr_c == '0);
      flags_c.rneg  = vnr_c[FIELD_W-1];
      flags_c.rpos  = !vnr_c[FIELD_W-1] && (vnr_c != '0);
      flags_c.dlz   = (dl_c == '0);
      flags_c.drz   = (dr_c == '0);
   end

   always_comb begin
      tl_c = s1_pl_ff + (s1_pl_ff[PROD_W-1] ? PROD_W'((1 << FRAC_BITS) - 1) : '0);
      tr_c = s1_pr_ff + (s1_pr_ff[PROD_W-1] ? PROD_W'((1 << FRAC_BITS) - 1) : '0);
      shl_c = tl_c >>> FRAC_BITS;
      shr_c = tr_c >>> FRAC_BITS;
      ll_c = s1_dl_ff * s1_sql_ff[FIELD_W-1:0];
      lh_c = s1_dl_ff * s1_sql_ff[PROD_W-1:FIELD_W];
      rl_c = s1_dr_ff * s1_sqr_ff[FIELD_W-1:0];
      rh_c = s1_dr_ff * s1_sqr_ff[PROD_W-1:FIELD_W];
   end

   always_comb begin
      fsum_c  = SUM_W'(s2_fl_ff) + SUM_W'(s2_fr_ff);
      fbias_c = fsum_c[SUM_W-1] ? SUM_W'(1) : SUM_W'(0);
      fhalf_c = (fsum_c + fbias_c) >>> 1;
      s3_in.fl    = s2_fl_ff;
      s3_in.fr    = s2_fr_ff;
      if (fsum_c[SUM_W-1] != fsum_c[SUM_W-2]) begin
         s3_in.fsat = fsum_c[SUM_W-1] ? {1'b1, {(FLUX_W-1){1'b0}}}
                                      : {1'b0, {(FLUX_W-1){1'b1}}};
      end else begin
         s3_in.fsat = fsum_c[FLUX_W-1:0];
      end
      s3_in.fhalf = fhalf_c[FLUX_W-1:0];
      s3_in.vl    = s2_vl_ff;
      s3_in.vr    = s2_vr_ff;
      s3_in.flags = s2_flags_ff;
      s3_in.roe_l = {{FIELD_W{1'b0}}, s2_ll_ff} + {s2_lh_ff, {FIELD_W{1'b0}}};
      s3_in.roe_r = {{FIELD_W{1'b0}}, s2_rl_ff} + {s2_rh_ff, {FIELD_W{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= in_valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_pl_ff    <= pl_c[PROD_W-1:0];
         s1_pr_ff    <= pr_c[PROD_W-1:0];
         s1_sql_ff   <= sql_c;
         s1_sqr_ff   <= sqr_c;
         s1_dl_ff    <= dl_c;
         s1_dr_ff    <= dr_c;
         s1_vl_ff    <= vl_c;
         s1_vr_ff    <= vr_c;
         s1_flags_ff <= flags_c;
      end
      if (rdy2) begin
         s2_fl_ff    <= shl_c[FLUX_W-1:0];
         s2_fr_ff    <= shr_c[FLUX_W-1:0];
         s2_ll_ff    <= ll_c;
         s2_lh_ff    <= lh_c;
         s2_rl_ff    <= rl_c;
         s2_rh_ff    <= rh_c;
         s2_vl_ff    <= s1_vl_ff;
         s2_vr_ff    <= s1_vr_ff;
         s2_flags_ff <= s1_flags_ff;
      end
      if (rdy3) begin
         s3_ff <= s3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = s3_ff;

endmodule

[hdl/pdu_select.sv]
// Stage 4: Roe sign, mode decision, mass result and lane operands for the
// momentum products. Depends on pdu_pkg.
`timescale 1ns / 1ps
module pdu_select (
   input  logic                      clock,
   input  logic                      reset,
   input  pdu_pkg::solver_mode_type  mode,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  pdu_pkg::front_type        in_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output pdu_pkg::sel_type          out_data
);
   import pdu_pkg::*;

   roe_sign_type sign_c;
   sel_type      sel_in;
   sel_type      sel_ff;
   logic         v4_ff;
   logic         rdy4;
   logic         lz_c, rz_c;

   assign rdy4 = !v4_ff || out_ready;
   assign in_ready = rdy4;

   always_comb begin
      lz_c = in_data.flags.dlz || in_data.flags.lzero;
      rz_c = in_data.flags.drz || in_data.flags.rzero;
      priority if (in_data.flags.dlz && in_data.flags.drz) begin
         sign_c = SIGN_NEG;
      end else if (lz_c) begin
         sign_c = rz_c ? SIGN_ZERO : (in_data.flags.rpos ? SIGN_POS : SIGN_NEG);
      end else if (rz_c || (in_data.flags.lpos == in_data.flags.rpos)) begin
         sign_c = in_data.flags.lpos ? SIGN_POS : SIGN_NEG;
      end else if (in_data.roe_l > in_data.roe_r) begin
         sign_c = in_data.flags.lpos ? SIGN_POS : SIGN_NEG;
      end else if (in_data.roe_l < in_data.roe_r) begin
         sign_c = in_data.flags.rpos ? SIGN_POS : SIGN_NEG;
      end else begin
         sign_c = SIGN_ZERO;
      end
   end

   always_comb begin
      sel_in.en_l = 1'b0;
      sel_in.en_r = 1'b0;
      sel_in.half = 1'b0;
      sel_in.mass = '0;
      unique case (mode)
         MODE_PENETRATE: begin
            sel_in.en_l = in_data.flags.lpos;
            sel_in.en_r = in_data.flags.rneg;
            if (sel_in.en_l && sel_in.en_r) begin
               sel_in.mass = in_data.fsat;
            end else if (sel_in.en_l) begin
               sel_in.mass = in_data.fl;
            end else if (sel_in.en_r) begin
               sel_in.mass = in_data.fr;
            end
         end
         MODE_ROE: begin
            if (!(in_data.flags.lneg && in_data.flags.rpos)) begin
               unique case (sign_c)
                  SIGN_POS: begin
                     sel_in.en_l = 1'b1;
                     sel_in.mass = in_data.fl;
                  end
                  SIGN_NEG: begin
                     sel_in.en_r = 1'b1;
                     sel_in.mass = in_data.fr;
                  end
                  default: begin
                     sel_in.en_l = 1'b1;
                     sel_in.half = 1'b1;
                     sel_in.mass = in_data.fhalf;
                  end
               endcase
            end
         end
         default: begin
            sel_in.mass = '0;
         end
      endcase
      sel_in.b_l = sel_in.half ? in_data.fhalf : in_data.fl;
      sel_in.b_r = in_data.fr;
      for (int c = 0; c < 3; c++) begin
         sel_in.a_r[c] = OP_W'($signed(in_data.vr[c]));
         sel_in.a_l[c] = sel_in.half
                       ? OP_W'($signed(in_data.vl[c])) + OP_W'($signed(in_data.vr[c]))
                       : OP_W'($signed(in_data.vl[c]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (rdy4) begin
         v4_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         sel_ff <= sel_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_data  = sel_ff;

endmodule

[hdl/pdu_lane.sv]
// One momentum product lane, stages 5-7: split multiply, partial product
// merge, truncating shift toward zero. Depends on pdu_pkg.
`timescale 1ns / 1ps
module pdu_lane (
   input  logic                              clock,
   input  logic                              load5,
   input  logic                              load6,
   input  logic                              load7,
   input  logic signed [pdu_pkg::OP_W-1:0]   a,
   input  logic signed [pdu_pkg::FLUX_W-1:0] b,
   input  logic                              en,
   input  logic                              half,
   output logic signed [pdu_pkg::MOM_W-1:0]  q
);
   import pdu_pkg::*;

   localparam int LO_W = OP_W + SPLIT_W + 1;
   localparam int HI_W = OP_W + FLUX_W - SPLIT_W;
   localparam int P_W  = OP_W + FLUX_W;

   logic signed [LO_W-1:0] plo_c, plo_ff;
   logic signed [HI_W-1:0] phi_c, phi_ff;
   logic                   en5_ff, half5_ff, en6_ff, half6_ff;
   logic signed [P_W-1:0]  p_c, p_ff, bias_c, t_c, sh_c;
   logic signed [MOM_W-1:0] q_in, q_ff;

   always_comb begin
      plo_c = a * $signed({1'b0, b[SPLIT_W-1:0]});
      phi_c = a * $signed(b[FLUX_W-1:SPLIT_W]);
      p_c = (P_W'(phi_ff) <<< SPLIT_W) + P_W'(plo_ff);
      if (p_ff[P_W-1]) begin
         bias_c = half6_ff ? P_W'((1 << (FRAC_BITS + 1)) - 1)
                           : P_W'((1 << FRAC_BITS) - 1);
      end else begin
         bias_c = '0;
      end
      t_c  = p_ff + bias_c;
      sh_c = half6_ff ? (t_c >>> (FRAC_BITS + 1)) : (t_c >>> FRAC_BITS);
      q_in = en6_ff ? sh_c[MOM_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (load5) begin
         plo_ff   <= plo_c;
         phi_ff   <= phi_c;
         en5_ff   <= en;
         half5_ff <= half;
      end
      if (load6) begin
         p_ff     <= p_c;
         en6_ff   <= en5_ff;
         half6_ff <= half5_ff;
      end
      if (load7) begin
         q_ff <= q_in;
      end
   end

   assign q = q_ff;

endmodule

[hdl/pdu_mom.sv]
// Back stages 5-8: six product lanes, lane sum and the result register.
// Depends on pdu_pkg and pdu_lane.
`timescale 1ns / 1ps
module pdu_mom (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  pdu_pkg::sel_type      in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output pdu_pkg::result_type   out_data
);
   import pdu_pkg::*;

   logic                     v5_ff, v6_ff, v7_ff, v8_ff;
   logic                     rdy5, rdy6, rdy7, rdy8;
   logic [FLUX_W-1:0]        m5_ff, m6_ff, m7_ff;
   logic signed [MOM_W-1:0]  q_l [3];
   logic signed [MOM_W-1:0]  q_r [3];
   result_type               res_in, res_ff;

   assign rdy8 = !v8_ff || out_ready;
   assign rdy7 = !v7_ff || rdy8;
   assign rdy6 = !v6_ff || rdy7;
   assign rdy5 = !v5_ff || rdy6;
   assign in_ready = rdy5;

   for (genvar c = 0; c < 3; c++) begin : g_lane
      pdu_lane u_lane_l (
         .clock (clock),
         .load5 (rdy5),
         .load6 (rdy6),
         .load7 (rdy7),
         .a     ($signed(in_data.a_l[c])),
         .b     (in_data.b_l),
         .en    (in_data.en_l),
         .half  (in_data.half),
         .q     (q_l[c])
      );
      pdu_lane u_lane_r (
         .clock (clock),
         .load5 (rdy5),
         .load6 (rdy6),
         .load7 (rdy7),
         .a     ($signed(in_data.a_r[c])),
         .b     (in_data.b_r),
         .en    (in_data.en_r),
         .half  (1'b0),
         .q     (q_r[c])
      );
   end

   always_comb begin
      res_in.mass = m7_ff;
      for (int c = 0; c < 3; c++) begin
         res_in.mom[c] = q_l[c] + q_r[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else begin
         if (rdy5) begin
            v5_ff <= in_valid;
         end
         if (rdy6) begin
            v6_ff <= v5_ff;
         end
         if (rdy7) begin
            v7_ff <= v6_ff;
         end
         if (rdy8) begin
            v8_ff <= v7_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy5) begin
         m5_ff <= in_data.mass;
      end
      if (rdy6) begin
         m6_ff <= m5_ff;
      end
      if (rdy7) begin
         m7_ff <= m6_ff;
      end
      if (rdy8) begin
         res_ff <= res_in;
      end
   end

   assign out_valid = v8_ff;
   assign out_data  = res_ff;

endmodule

[hdl/pressureless_dust_upwind_flux.sv]
// Pressureless dust upwind face flux, top level.
// Throughput: one face per cycle while the result side takes beats; eight register
// stages, each with its own valid, set by the split 33x48 momentum multipliers
// and the 96-bit Roe compare.
// Reset (synchronous): empties the pipeline, solver mode Roe, normal x.
// Depends on pdu_pkg, pdu_if, pdu_front, pdu_select, pdu_mom.
`timescale 1ns / 1ps
module pressureless_dust_upwind_flux #(
   parameter int VALUE_WIDTH = pdu_pkg::VALUE_WIDTH_DEFAULT
) (
   input logic          clock,
   input logic          reset,
   pdu_req_if.sink      req_bus,
   pdu_rsp_if.source    rsp_bus,
   pdu_csr_if.sink      csr_bus
);
   import pdu_pkg::*;

   solver_mode_type solver_mode_ff;
   logic [1:0]      normal_dir_ff;
   item_type        item;
   front_type       front_data;
   sel_type         sel_data;
   result_type      res_data;
   logic            front_valid, front_ready, sel_valid, sel_ready;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         solver_mode_ff <= MODE_ROE;
         normal_dir_ff  <= DIR_X;
      end else if (csr_bus.valid) begin
         priority if (csr_bus.index == CSR_SOLVER_MODE) begin
            solver_mode_ff <= solver_mode_type'(csr_bus.data[0]);
         end else if (csr_bus.index == CSR_NORMAL_DIR) begin
            normal_dir_ff <= csr_bus.data[1:0];
         end else begin
            normal_dir_ff <= normal_dir_ff;
         end
      end
   end

   always_comb begin
      item.rho_l  = req_bus.rho_left;
      item.v_l[0] = req_bus.vx_left;
      item.v_l[1] = req_bus.vy_left;
      item.v_l[2] = req_bus.vz_left;
      item.rho_r  = req_bus.rho_right;
      item.v_r[0] = req_bus.vx_right;
      item.v_r[1] = req_bus.vy_right;
      item.v_r[2] = req_bus.vz_right;
   end

   pdu_front #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .normal_dir (normal_dir_ff),
      .in_valid   (req_bus.valid),
      .in_ready   (req_bus.ready),
      .in_item    (item),
      .out_valid  (front_valid),
      .out_ready  (front_ready),
      .out_data   (front_data)
   );

   pdu_select u_select (
      .clock     (clock),
      .reset     (reset),
      .mode      (solver_mode_ff),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (sel_valid),
      .out_ready (sel_ready),
      .out_data  (sel_data)
   );

   pdu_mom u_mom (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sel_valid),
      .in_ready  (sel_ready),
      .in_data   (sel_data),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (res_data)
   );

   assign rsp_bus.mass_flux  = res_data.mass;
   assign rsp_bus.mom_flux_x = res_data.mom[0];
   assign rsp_bus.mom_flux_y = res_data.mom[1];
   assign rsp_bus.mom_flux_z = res_data.mom[2];

`ifndef SYNTHESIS
   a_reset_regs: assert property (@(posedge clock)
      reset |=> (solver_mode_ff == MODE_ROE && normal_dir_ff == DIR_X))
      else $error("register reset values wrong");

   a_dir_write: assert property (@(posedge clock) disable iff (reset)
      csr_bus.valid && csr_bus.index == CSR_NORMAL_DIR
      |=> normal_dir_ff == $past(csr_bus.data[1:0]))
      else $error("normal direction write lost");

   a_mode_write: assert property (@(posedge clock) disable iff (reset)
      csr_bus.valid && csr_bus.index == CSR_SOLVER_MODE
      |=> solver_mode_ff == solver_mode_type'($past(csr_bus.data[0])))
      else $error("solver mode write lost");

   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.ready |-> req_bus.ready)
      else $error("pipeline stalls with result side ready");
`endif

endmodule

[tb/sv/pressureless_dust_upwind_flux_tb.sv]
// Self-checking testbench for the pressureless dust upwind flux block: directed
// faces and random faces checked against an in-bench flux predictor under varied flow control.
// Depends on pdu_pkg, pdu_if and the pressureless_dust_upwind_flux RTL.
`timescale 1ns / 1ps
module pressureless_dust_upwind_flux_tb;
   import pdu_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd2;
   localparam longint FLUX_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint FLUX_MIN = 64'sh8000_0000_0000_0000;
   localparam logic [31:0] VEL_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] VEL_MIN = 32'h8000_0000;
   localparam logic [31:0] RHO_MAX = 32'hFFFF_FFFF;
   localparam logic [31:0] ONE = 32'h0001_0000;

   typedef struct packed {
      field_type       rho_l;
      field_type [2:0] v_l;
      field_type       rho_r;
      field_type [2:0] v_r;
   } face_type;

   typedef struct packed {
      logic [FLUX_W-1:0] mass;
      logic [MOM_W-1:0]  mx;
      logic [MOM_W-1:0]  my;
      logic [MOM_W-1:0]  mz;
   } flux_type;

   logic clock;
   logic reset;
   pdu_req_if req_bus ();
   pdu_rsp_if rsp_bus ();
   pdu_csr_if csr_bus ();

   pressureless_dust_upwind_flux DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   flux_type        flux_expected[$];
   int              error_count = 0;
   int              send_idle_pct = 0;
   int              recv_stall_pct = 0;
   solver_mode_type mode_shadow;
   logic [1:0]      dir_shadow;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("pressureless_dust_upwind_flux_tb failed");
      $finish;
   end

   function automatic longint mul_shift(longint a, longint b, int sh);
      logic [127:0] p;
      logic [63:0]  ma, mb, m;
      bit           neg;
      neg = (a < 0) != (b < 0);
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      p = {64'd0, ma} * {64'd0, mb};
      if ((p >> (64 + sh)) != 0) return neg ? FLUX_MIN : FLUX_MAX;
      m = p >> sh;
      if (neg) return m[63] ? FLUX_MIN : -$signed(m);
      return m[63] ? FLUX_MAX : $signed(m);
   endfunction

   function automatic longint add_sat(longint a, longint b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'(FLUX_MAX)) return FLUX_MAX;
      if (s < 65'(FLUX_MIN)) return FLUX_MIN;
      return longint'(s);
   endfunction

   function automatic int upwind_sign(longint dl, longint vl, longint dr, longint vr);
      int           sl, sr;
      logic [63:0]  ml, mr;
      logic [127:0] wl, wr;
      if (dl == 0 && dr == 0) return -1;
      sl = (dl == 0 || vl == 0) ? 0 : (vl > 0 ? 1 : -1);
      sr = (dr == 0 || vr == 0) ? 0 : (vr > 0 ? 1 : -1);
      if (sl == 0) return sr;
      if (sr == 0 || sl == sr) return sl;
      ml = (vl < 0) ? -vl : vl;
      mr = (vr < 0) ? -vr : vr;
      wl = {64'd0, dl} * {64'd0, ml * ml};
      wr = {64'd0, dr} * {64'd0, mr * mr};
      if (wl == wr) return 0;
      return (wl > wr) ? sl : sr;
   endfunction

   function automatic flux_type predict_flux(face_type f);
      longint  dl, dr, fl, fr, mass;
      longint  vl[3], vr[3], mom[3];
      int      nd, s;
      bit      tl, tr;
      flux_type r;
      dl = longint'({32'd0, f.rho_l});
      dr = longint'({32'd0, f.rho_r});
      for (int c = 0; c < 3; c++) begin
         vl[c] = longint'($signed(f.v_l[c]));
         vr[c] = longint'($signed(f.v_r[c]));
      end
      nd = (dir_shadow == 2'd3) ? 0 : dir_shadow;
      fl = mul_shift(dl, vl[nd], FRAC_BITS);
      fr = mul_shift(dr, vr[nd], FRAC_BITS);
      if (mode_shadow == MODE_PENETRATE) begin
         tl = vl[nd] > 0;
         tr = vr[nd] < 0;
         mass = (tl ? fl : 0) + (tr ? fr : 0);
         for (int c = 0; c < 3; c++)
            mom[c] = add_sat(tl ? mul_shift(vl[c], fl, FRAC_BITS) : 0,
                             tr ? mul_shift(vr[c], fr, FRAC_BITS) : 0);
      end else if (vl[nd] < 0 && vr[nd] > 0) begin
         mass = 0;
         for (int c = 0; c < 3; c++) mom[c] = 0;
      end else begin
         s = upwind_sign(dl, vl[nd], dr, vr[nd]);
         if (s > 0) begin
            mass = fl;
            for (int c = 0; c < 3; c++) mom[c] = mul_shift(vl[c], mass, FRAC_BITS);
         end else if (s < 0) begin
            mass = fr;
            for (int c = 0; c < 3; c++) mom[c] = mul_shift(vr[c], mass, FRAC_BITS);
         end else begin
            mass = (fl + fr) / 2;
            for (int c = 0; c < 3; c++)
               mom[c] = mul_shift(vl[c] + vr[c], mass, FRAC_BITS + 1);
         end
      end
      if (mass >= (64'sd1 <<< 47)) mass = (64'sd1 <<< 47) - 1;
      else if (mass < -(64'sd1 <<< 47)) mass = -(64'sd1 <<< 47);
      r.mass = mass[FLUX_W-1:0];
      r.mx = mom[0];
      r.my = mom[1];
      r.mz = mom[2];
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("%0t: %s mismatch: got %h expected %h", $realtime, field, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      flux_type w;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (flux_expected.size() == 0) begin
            report_mismatch("unexpected beat", 64'(rsp_bus.mass_flux), 64'd0);
         end else begin
            w = flux_expected.pop_front();
            if (rsp_bus.mass_flux !== w.mass)
               report_mismatch("mass_flux", 64'(rsp_bus.mass_flux), 64'(w.mass));
            if (rsp_bus.mom_flux_x !== w.mx)
               report_mismatch("mom_flux_x", rsp_bus.mom_flux_x, w.mx);
            if (rsp_bus.mom_flux_y !== w.my)
               report_mismatch("mom_flux_y", rsp_bus.mom_flux_y, w.my);
            if (rsp_bus.mom_flux_z !== w.mz)
               report_mismatch("mom_flux_z", rsp_bus.mom_flux_z, w.mz);
         end
      end
   end

   task automatic send_face(face_type f);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.rho_left  <= f.rho_l;
      req_bus.vx_left   <= f.v_l[0];
      req_bus.vy_left   <= f.v_l[1];
      req_bus.vz_left   <= f.v_l[2];
      req_bus.rho_right <= f.rho_r;
      req_bus.vx_right  <= f.v_r[0];
      req_bus.vy_right  <= f.v_r[1];
      req_bus.vz_right  <= f.v_r[2];
      do @(posedge clock); while (!req_bus.ready);
      flux_expected.push_back(predict_flux(f));
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      req_bus.valid <= 1'b0;
      while (flux_expected.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      if (idx == CSR_SOLVER_MODE) mode_shadow = solver_mode_type'(value[0]);
      else if (idx == CSR_NORMAL_DIR) dir_shadow = value[1:0];
      @(posedge clock);
   endtask

   function automatic field_type pick_velocity();
      case ($urandom_range(9))
         0: return VEL_MIN;
         1: return VEL_MAX;
         2: return 32'd0;
         3: return $urandom_range(1) ? ONE : -ONE;
         4: return $urandom_range(1) ? 32'd1 : 32'hFFFF_FFFF;
         5: return 32'($signed($urandom_range(2 * 65536 * 8)) - 65536 * 8);
         default: return $urandom;
      endcase
   endfunction

   function automatic field_type pick_density();
      case ($urandom_range(7))
         0: return 32'd0;
         1: return RHO_MAX;
         2: return ONE;
         3: return $urandom_range(65536 * 16);
         default: return $urandom;
      endcase
   endfunction

   function automatic face_type random_face();
      face_type f;
      int nd;
      f.rho_l = pick_density();
      f.rho_r = pick_density();
      for (int c = 0; c < 3; c++) begin
         f.v_l[c] = pick_velocity();
         f.v_r[c] = pick_velocity();
      end
      nd = (dir_shadow == 2'd3) ? 0 : dir_shadow;
      if ($urandom_range(7) == 0) begin
         f.rho_r = f.rho_l;
         f.v_r[nd] = -f.v_l[nd];
      end
      return f;
   endfunction

   function automatic face_type make_face(field_type dl, field_type vl, field_type dr,
                                          field_type vr);
      face_type f;
      f.rho_l = dl;
      f.rho_r = dr;
      for (int c = 0; c < 3; c++) begin
         f.v_l[c] = vl ^ (32'h0003_1234 * c);
         f.v_r[c] = vr ^ (32'h0002_4321 * c);
      end
      f.v_l[0] = vl;
      f.v_r[0] = vr;
      return f;
   endfunction

   task automatic test_directed_roe();
      send_face(make_face(RHO_MAX, VEL_MAX, RHO_MAX, VEL_MAX));
      send_face(make_face(RHO_MAX, VEL_MIN, RHO_MAX, VEL_MIN));
      send_face(make_face(RHO_MAX, VEL_MIN, RHO_MAX, VEL_MAX));
      send_face(make_face(32'd0, ONE, 32'd0, ONE));
      send_face(make_face(ONE, 2 * ONE, 4 * ONE, -ONE));
      send_face(make_face(3 * ONE, 5 * ONE, 3 * ONE, -5 * ONE));
      send_face(make_face(RHO_MAX, VEL_MAX, RHO_MAX, -VEL_MAX));
      send_face(make_face(ONE, 32'd0, 2 * ONE, 32'd0));
      send_face(make_face(RHO_MAX, 32'd1, 32'd0, VEL_MIN));
      send_face(make_face(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555));
   endtask

   task automatic test_directed_penetration();
      write_csr(CSR_SOLVER_MODE, {7'h55, MODE_PENETRATE});
      send_face(make_face(RHO_MAX, VEL_MAX, RHO_MAX, VEL_MIN));
      send_face(make_face(RHO_MAX, VEL_MIN, RHO_MAX, VEL_MAX));
      send_face(make_face(ONE, ONE, ONE, -ONE));
      send_face(make_face(32'd0, ONE, 32'd0, -ONE));
      send_face(make_face(RHO_MAX, 32'd0, RHO_MAX, 32'd0));
      send_face(make_face(32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA));
      write_csr(CSR_NORMAL_DIR, {6'h2A, DIR_Z});
      send_face(make_face(RHO_MAX, VEL_MAX, RHO_MAX, VEL_MIN));
      write_csr(CSR_SPARE, 8'hFF);
      send_face(make_face(ONE, -ONE, 2 * ONE, -2 * ONE));
   endtask

   task automatic test_random_sweep();
      for (int blk = 0; blk < 8; blk++) begin
         write_csr(CSR_SOLVER_MODE, 8'($urandom) & 8'hFE | 8'(blk[0]));
         write_csr(CSR_NORMAL_DIR, 8'($urandom) & 8'hFC | 8'(blk[2:1]));
         case (blk % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
         endcase
         repeat (150) send_face(random_face());
      end
   endtask

   initial begin
      reset = 1'b1;
      mode_shadow = MODE_ROE;
      dir_shadow = DIR_X;
      req_bus.valid <= 1'b0;
      req_bus.rho_left <= '0;
      req_bus.vx_left <= '0;
      req_bus.vy_left <= '0;
      req_bus.vz_left <= '0;
      req_bus.rho_right <= '0;
      req_bus.vx_right <= '0;
      req_bus.vy_right <= '0;
      req_bus.vz_right <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= '0;
      csr_bus.data <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_roe();
      test_directed_penetration();
      test_random_sweep();
      req_bus.valid <= 1'b0;
      while (flux_expected.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("pressureless_dust_upwind_flux_tb passed");
      end else begin
         $display("pressureless_dust_upwind_flux_tb failed");
      end
      $finish;
   end

endmodule

[pressureless_dust_upwind_flux.f]
hdl/pdu_pkg.sv
hdl/pdu_if.sv
hdl/pdu_front.sv
hdl/pdu_select.sv
hdl/pdu_lane.sv
hdl/pdu_mom.sv
hdl/pressureless_dust_upwind_flux.sv
tb/sv/pressureless_dust_upwind_flux_tb.sv
